>>> rtl/core/lrudc_pkg.sv
// Package for the LRU document cache tracker.
// Holds default sizes, the sequencer state type and the cell control struct.
// No dependencies.
`default_nettype none

package lrudc_pkg;

   localparam int unsigned MAX_ENTRIES_DEF = 16;
   localparam int unsigned INDEX_WIDTH_DEF = 20;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } lrudc_state_type;

   // Control broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic compare;   // register tag match against the key
      logic update;    // shift toward the least recent end or load the key
   } lrudc_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/core/lrudc_cell.sv
// One slot of the recency chain: a tag, its valid bit and a registered match flag.
// Depends on lrudc_pkg for the control struct.
`default_nettype none

module lrudc_cell #(
   parameter int unsigned INDEX_WIDTH = lrudc_pkg::INDEX_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lrudc_pkg::lrudc_ctrl_type ctrl,
   input  wire logic [INDEX_WIDTH-1:0]  key,
   input  wire logic [INDEX_WIDTH-1:0]  prev_tag,
   input  wire logic                    prev_valid,
   input  wire logic                    hit_above_in,
   output logic [INDEX_WIDTH-1:0]       tag,
   output logic                         valid,
   output logic                         hit_above_out
);

   logic [INDEX_WIDTH-1:0] tag_ff;
   logic                   valid_ff;
   logic                   hit_ff;

   // Payload: take the neighbor's tag unless a more recent slot holds the hit.
   always_ff @(posedge clock) begin
      if (ctrl.update && !hit_above_in) begin
         tag_ff <= prev_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         if (ctrl.compare) begin
            hit_ff <= valid_ff && (tag_ff == key);
         end
         if (ctrl.update && !hit_above_in) begin
            valid_ff <= prev_valid;
         end
      end
   end

   assign tag           = tag_ff;
   assign valid         = valid_ff;
   assign hit_above_out = hit_above_in | hit_ff;

endmodule

`default_nettype wire

>>> rtl/core/lru_document_cache_tracker.sv
// Top level of the LRU document cache tracker: sequencer, key register and cell chain.
// Depends on lrudc_pkg and lrudc_cell.
`default_nettype none

// Usage
//   Request channel: drive req_hit_index and raise start; the transaction is
//   taken at the rising edge where start is high and busy is low.
//   Response channel: rsp_strobe is high for exactly one cycle and marks
//   rsp_was_cached, rsp_evict_valid and rsp_evicted_index. There is one
//   response per request, in request order. The receiver cannot stall.
//   Sequencing: a request has a match step and then a shift step. The
//   match step registers the tag match in every cell of the chain; the
//   shift step moves the chain one place toward the least recent end up to
//   the hit slot (or over the whole chain on a miss) and loads the key into
//   the most recent slot. busy is high only during the match step, so a new
//   request is taken while the shift of the previous one completes.
//   Eviction: a miss with the last slot valid drops that slot and reports
//   its tag; otherwise rsp_evicted_index reads zero.
//   Reset: synchronous, active high; empties the directory (all valid bits
//   cleared) and returns the sequencer to idle. No clearing pass is needed.
module lru_document_cache_tracker #(
   parameter int unsigned MAX_ENTRIES = lrudc_pkg::MAX_ENTRIES_DEF,
   parameter int unsigned INDEX_WIDTH = lrudc_pkg::INDEX_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [INDEX_WIDTH-1:0] req_hit_index,
   output logic                        rsp_strobe,
   output logic                        rsp_was_cached,
   output logic                        rsp_evict_valid,
   output logic [INDEX_WIDTH-1:0]      rsp_evicted_index
);

   lrudc_pkg::lrudc_state_type state_ff, state_in;
   lrudc_pkg::lrudc_ctrl_type  ctrl;

   logic [INDEX_WIDTH-1:0] key_ff;
   logic                   accept;

   logic                   rsp_strobe_ff;
   logic                   rsp_was_cached_ff;
   logic                   rsp_evict_valid_ff;
   logic [INDEX_WIDTH-1:0] rsp_evicted_index_ff;

   // Chain links: entry 0 feeds the most recent cell, entry MAX_ENTRIES
   // is what leaves the least recent cell.
   logic [INDEX_WIDTH-1:0] chain_tag   [MAX_ENTRIES+1];
   logic                   chain_valid [MAX_ENTRIES+1];
   logic                   chain_hit   [MAX_ENTRIES+1];

   // Accept while idle or while finishing the shift of the previous transaction.
   assign busy   = (state_ff == lrudc_pkg::ST_COMPARE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrudc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl.compare = 1'b0;
      ctrl.update  = 1'b0;
      unique case (state_ff)
         lrudc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lrudc_pkg::ST_COMPARE;
            end
         end
         lrudc_pkg::ST_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = lrudc_pkg::ST_UPDATE;
         end
         lrudc_pkg::ST_UPDATE: begin
            ctrl.update = 1'b1;
            state_in    = accept ? lrudc_pkg::ST_COMPARE : lrudc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrudc_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the key for the match and the load into the front slot.
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_hit_index;
      end
   end

   // The key enters at the front as a valid entry; nothing above slot 0 hits.
   assign chain_tag[0]   = key_ff;
   assign chain_valid[0] = 1'b1;
   assign chain_hit[0]   = 1'b0;

   for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      lrudc_cell #(
         .INDEX_WIDTH (INDEX_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .key           (key_ff),
         .prev_tag      (chain_tag[gi]),
         .prev_valid    (chain_valid[gi]),
         .hit_above_in  (chain_hit[gi]),
         .tag           (chain_tag[gi+1]),
         .valid         (chain_valid[gi+1]),
         .hit_above_out (chain_hit[gi+1])
      );
   end

   // Register the response in the shift cycle, from pre-shift contents.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.update;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         rsp_was_cached_ff  <= chain_hit[MAX_ENTRIES];
         rsp_evict_valid_ff <= !chain_hit[MAX_ENTRIES] && chain_valid[MAX_ENTRIES];
         if (!chain_hit[MAX_ENTRIES] && chain_valid[MAX_ENTRIES]) begin
            rsp_evicted_index_ff <= chain_tag[MAX_ENTRIES];
         end else begin
            rsp_evicted_index_ff <= '0;
         end
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_was_cached    = rsp_was_cached_ff;
   assign rsp_evict_valid   = rsp_evict_valid_ff;
   assign rsp_evicted_index = rsp_evicted_index_ff;

endmodule

`default_nettype wire

>>> tb/tb_lru_document_cache_tracker.sv
// Self-checking testbench for lru_document_cache_tracker: a scripted access sequence, then
// random accesses, checked against a recency-directory predictor kept alongside the DUT.
// Depends on lrudc_pkg for the default directory sizes.
`default_nettype none

module tb_lru_document_cache_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH = lrudc_pkg::MAX_ENTRIES_DEF;
   localparam int unsigned IW = lrudc_pkg::INDEX_WIDTH_DEF;
   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned STALL_LIMIT = 2000;   // cycles with no transaction on either side
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned RANDOM_PER_PHASE = 400;
   localparam int unsigned HOT_SET_SIZE = 24;    // larger than the directory: hits and evictions
   localparam int unsigned SCRIPT_LEN = 25;

   localparam logic [IW-1:0] IDX_ZERO = '0;
   localparam logic [IW-1:0] IDX_MAX = '1;

   typedef struct packed {
      logic          was_cached;
      logic          evict_valid;
      logic [IW-1:0] evicted_index;
   } lookup_result_type;

   typedef struct packed {
      logic [IW-1:0]     hit_index;
      logic              typed;       // expected result written into the row
      lookup_result_type known;
   } script_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [IW-1:0] req_hit_index = '0;
   logic          rsp_strobe;
   logic          rsp_was_cached;
   logic          rsp_evict_valid;
   logic [IW-1:0] rsp_evicted_index;

   // Side channel from the driver to the monitor: the row that is on the request ports.
   logic              row_typed = 1'b0;
   lookup_result_type row_known = '0;

   // Predicted directory, most recent entry in slot 0.
   logic [IW-1:0] dir_tag [DEPTH];
   logic          dir_valid [DEPTH];
   int            dir_count;

   lookup_result_type lookups_due [$];
   int                mismatch_count = 0;
   logic [IW-1:0]     hot_set [HOT_SET_SIZE];

   // Scripted accesses. Tag zero first: after reset every slot is invalid, so it must miss.
   // The fill walks a one across the low bits until the directory is full, then a miss
   // evicts the oldest entry (all ones), a hit lands in the last slot, and a victim returns.
   script_row_type access_script [SCRIPT_LEN] = '{
      '{IDX_ZERO,    1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{IDX_ZERO,    1'b1, '{1'b1, 1'b0, IDX_ZERO}},   // hit on the most recent entry
      '{IDX_MAX,     1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{IDX_MAX,     1'b1, '{1'b1, 1'b0, IDX_ZERO}},
      '{IDX_ZERO,    1'b1, '{1'b1, 1'b0, IDX_ZERO}},   // hit one below the head
      '{20'h00001,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00002,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00004,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00008,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00010,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00020,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00040,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00080,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00100,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00200,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00400,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h00800,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h01000,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},
      '{20'h02000,   1'b1, '{1'b0, 1'b0, IDX_ZERO}},   // directory now full
      '{20'h80000,   1'b1, '{1'b0, 1'b1, IDX_MAX}},    // miss when full: oldest dropped
      '{20'h80000,   1'b1, '{1'b1, 1'b0, IDX_ZERO}},
      '{IDX_ZERO,    1'b1, '{1'b1, 1'b0, IDX_ZERO}},   // hit in the least recent slot
      '{20'h7FFFF,   1'b0, '0},
      '{20'h00001,   1'b0, '0},                        // the victim comes back as a miss
      '{IDX_MAX,     1'b0, '0}
   };

   lru_document_cache_tracker #(
      .MAX_ENTRIES(DEPTH),
      .INDEX_WIDTH(IW)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_hit_index(req_hit_index),
      .rsp_strobe(rsp_strobe),
      .rsp_was_cached(rsp_was_cached),
      .rsp_evict_valid(rsp_evict_valid),
      .rsp_evicted_index(rsp_evicted_index)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Move slots 0 .. upto-1 one place toward the least recent end.
   function automatic void age_entries(input int upto);
      for (int s = upto; s > 0; s--) begin
         if (s < DEPTH) begin
            dir_tag[s] = dir_tag[s-1];
            dir_valid[s] = dir_valid[s-1];
         end
      end
   endfunction

   // Look the key up, promote or insert it, and return what the DUT must report.
   function automatic lookup_result_type touch_directory(input logic [IW-1:0] key);
      lookup_result_type res;
      int hit_slot;
      res = '0;
      hit_slot = -1;
      for (int s = 0; s < dir_count; s++) begin
         if (hit_slot < 0 && dir_valid[s] && dir_tag[s] == key) begin
            hit_slot = s;
         end
      end
      if (hit_slot >= 0) begin
         res.was_cached = 1'b1;
         age_entries(hit_slot);
      end else if (dir_count >= DEPTH) begin
         // Full: drop the tail and report it.
         res.evict_valid = 1'b1;
         res.evicted_index = dir_tag[DEPTH-1];
         age_entries(DEPTH - 1);
      end else begin
         age_entries(dir_count);
         dir_count++;
      end
      dir_tag[0] = key;
      dir_valid[0] = 1'b1;
      return res;
   endfunction

   // Mostly revisit a small working set or a live entry, so hits, promotions from every
   // depth and evictions all occur; the rest are indices from the whole range.
   function automatic logic [IW-1:0] pick_hit_index();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45) begin
         return hot_set[$urandom_range(HOT_SET_SIZE - 1)];
      end
      if (roll < 75 && dir_count != 0) begin
         return dir_tag[$urandom_range(dir_count - 1)];
      end
      return IW'($urandom);
   endfunction

   // Present one access and hold it until the DUT takes the transaction. Each cycle before
   // it, hold start low with probability idle_pct, so gaps hit both the match and shift steps.
   task automatic issue_access(input logic [IW-1:0] idx, input logic typed,
                               input lookup_result_type known, input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_hit_index <= idx;
      row_typed <= typed;
      row_known <= known;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic refill_hot_set();
      foreach (hot_set[k]) hot_set[k] = IW'($urandom);
   endtask

   // Predict on every accepted request; check every response against the oldest prediction.
   always @(posedge clock) begin
      lookup_result_type got;
      lookup_result_type want;
      if (!reset) begin
         if (start && !busy) begin
            got = touch_directory(req_hit_index);
            lookups_due = {lookups_due, (row_typed ? row_known : got)};
         end
         if (rsp_strobe) begin
            if (lookups_due.size() == 0) begin
               $display("%0t ns: response with none expected: cached %0d evict %0d index %h",
                        $time, rsp_was_cached, rsp_evict_valid, rsp_evicted_index);
               mismatch_count++;
            end else begin
               want = lookups_due.pop_front();
               if (rsp_was_cached !== want.was_cached) begin
                  $display("%0t ns: rsp_was_cached expected %0d actual %0d",
                           $time, want.was_cached, rsp_was_cached);
                  mismatch_count++;
               end
               if (rsp_evict_valid !== want.evict_valid) begin
                  $display("%0t ns: rsp_evict_valid expected %0d actual %0d",
                           $time, want.evict_valid, rsp_evict_valid);
                  mismatch_count++;
               end
               if (rsp_evicted_index !== want.evicted_index) begin
                  $display("%0t ns: rsp_evicted_index expected %h actual %h",
                           $time, want.evicted_index, rsp_evicted_index);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run when neither side completes a transaction for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("[lru_document_cache_tracker] ERROR");
      $finish;
   end

   initial begin
      int unsigned phase_idle [3];
      foreach (dir_tag[s]) begin
         dir_tag[s] = '0;
         dir_valid[s] = 1'b0;
      end
      dir_count = 0;
      // Sender idles often, then very often, then never.
      phase_idle = '{37, 72, 0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Scripted part.
      foreach (access_script[r]) begin
         issue_access(access_script[r].hit_index, access_script[r].typed,
                      access_script[r].known, phase_idle[0]);
      end

      // Random part, one working set per idle phase.
      foreach (phase_idle[p]) begin
         refill_hot_set();
         repeat (RANDOM_PER_PHASE) begin
            issue_access(pick_hit_index(), 1'b0, '0, phase_idle[p]);
         end
      end
      start <= 1'b0;

      // Drain the outstanding responses, then give stray strobes a chance to show up.
      while (lookups_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && lookups_due.size() == 0) begin
         $display("[lru_document_cache_tracker] OK");
      end else begin
         $display("[lru_document_cache_tracker] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> lru_document_cache_tracker.f
rtl/core/lrudc_pkg.sv
rtl/core/lrudc_cell.sv
rtl/core/lru_document_cache_tracker.sv
tb/tb_lru_document_cache_tracker.sv
